// ----- rtl/hvd_pkg.sv -----
// hvd_pkg: shared types, codes and saturating arithmetic for the HMM Viterbi decoder.
// No dependencies; used by hvd_stream_if users and hmm_viterbi_decoder.
package hvd_pkg;

  // action codes of an input transaction
  localparam logic [1:0] ACT_TRANS = 2'd0;
  localparam logic [1:0] ACT_EMIS  = 2'd1;
  localparam logic [1:0] ACT_OBS   = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_STATES  = 1'b0;
  localparam logic REG_SYMBOLS = 1'b1;

  localparam logic [6:0] RESET_STATES  = 7'd62;
  localparam logic [4:0] RESET_SYMBOLS = 5'd12;

  localparam logic signed [31:0] FLOOR_METRIC = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_METRIC   = 32'sh7fff_ffff;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         row;
    logic [5:0]         column;
    logic signed [15:0] value;
    logic               last_of_frame;
    logic               last_of_sequence;
  } hvd_in_t;

  typedef struct packed {
    logic [5:0]         state_index;
    logic [5:0]         step_index;
    logic signed [31:0] path_score;
    logic               overflow;
    logic               last;
  } hvd_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIS,
    ST_ACS,
    ST_WRITE,
    ST_COPY,
    ST_FEND,
    ST_FIND,
    ST_WALK,
    ST_WALK_WAIT,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT,
    ST_RESTART
  } hvd_state_e;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      return s[32] ? FLOOR_METRIC : MAX_METRIC;
    end
    return s[31:0];
  endfunction

endpackage

// ----- rtl/hvd_stream_if.sv -----
// hvd_stream_if: valid/ready channel carrying one payload per transaction.
// Payload type is a parameter; no package dependency.
interface hvd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/hmm_viterbi_decoder.sv -----
// hmm_viterbi_decoder: log-domain HMM Viterbi decoder, top level.
// Depends on hvd_pkg and hvd_stream_if.
//
// Input transactions either load one Q8.8 word of the transition or emission
// table or carry one Q1.15 observation weight. The weight flagged
// last_of_frame triggers a decode step while step capacity is left (else it
// only sets overflow): for each of S states the emission dot product over M
// weights through the emission memory, then an add-compare-select pass over
// all S predecessors reading the metric and transition memories, one write
// of the new metric and back pointer. New metrics go to a scratch memory and
// are copied back so unused states keep their metric. Each memory has a
// single read port.
// With last_of_sequence the best final state is found, the back pointer
// memory is walked and one result per stored frame is sent in frame order,
// each held until the output takes it.
// Input is taken only while no frame or traceback work is under way. Metrics
// reset through valid bits, so there is no clearing pass after reset.
module hmm_viterbi_decoder #(
  parameter int MAX_STATES  = 64,
  parameter int MAX_SYMBOLS = 16,
  parameter int MAX_STEPS   = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hvd_stream_if.sink   in_i,
  hvd_stream_if.source out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import hvd_pkg::*;

  localparam int SW   = $clog2(MAX_STATES);
  localparam int CW   = $clog2(MAX_STATES + 1);
  localparam int MW   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int MCW  = $clog2(MAX_SYMBOLS + 1);
  localparam int TW   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int NW   = $clog2(MAX_STEPS + 1);
  localparam int CNTW = (CW > MCW) ? CW : MCW;
  localparam int AW   = 33 + MW;
  localparam int TAW  = $clog2(MAX_STATES * MAX_STATES);
  localparam int EAW  = $clog2(MAX_STATES * MAX_SYMBOLS);
  localparam int BAW  = $clog2(MAX_STEPS * MAX_STATES);

  // ---------------- configuration ----------------
  logic [6:0] states_q;
  logic [4:0] symbols_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SYMBOLS) ? {27'd0, symbols_q} : {25'd0, states_q};

  logic [CW-1:0]  s_use;
  logic [MCW-1:0] m_use;

  always_comb begin
    if (states_q == 7'd0) begin
      s_use = CW'(1);
    end else if (int'(states_q) > MAX_STATES) begin
      s_use = CW'(MAX_STATES);
    end else begin
      s_use = CW'(states_q);
    end
    if (symbols_q == 5'd0) begin
      m_use = MCW'(1);
    end else if (int'(symbols_q) > MAX_SYMBOLS) begin
      m_use = MCW'(MAX_SYMBOLS);
    end else begin
      m_use = MCW'(symbols_q);
    end
  end

  // ---------------- control state ----------------
  hvd_state_e state_q, state_d;

  logic [CNTW-1:0]     cnt_q;
  logic [SW-1:0]       j_q;
  logic                rd_v_q, prod_v_q, cand_v_q;
  logic [SW-1:0]       rd_idx_q, cand_idx_q;
  logic                eos_q;
  logic [NW-1:0]       step_q;
  logic                ovf_q;
  logic [MAX_STATES-1:0]  mvld_q;
  logic [MAX_SYMBOLS-1:0] wvld_q;
  logic [TW-1:0]       walk_q, o_q;
  logic [SW-1:0]       cur_q;

  // payload registers
  logic signed [31:0]  prod_q, cand_q, best_q, score_q;
  logic signed [AW-1:0] acc_q;
  logic [SW-1:0]       pred_q;
  hvd_out_t            out_q;

  // memory read data
  logic signed [15:0]  e_rd_q, w_rd_q, t_rd_q;
  logic signed [31:0]  m_rd_q, n_rd_q;
  logic [SW-1:0]       bp_rd_q, seq_rd_q;
  logic                wvld_rd_q, mvld_rd_q, mzero_rd_q;

  logic in_acc, out_acc, frame_end;
  assign in_acc    = in_i.valid && in_i.ready;
  assign out_acc   = out_o.valid && out_o.ready;
  assign frame_end = in_acc && (in_i.data.action == ACT_OBS) && in_i.data.last_of_frame;

  // phase sequencing: issue reads while the count is below the limit
  logic [CNTW-1:0] lim;
  logic            issue, done, j_last, o_last;

  assign lim = (state_q == ST_EMIS) ? CNTW'(m_use) : CNTW'(s_use);
  assign issue = ((state_q == ST_EMIS) || (state_q == ST_ACS) ||
                  (state_q == ST_COPY) || (state_q == ST_FIND)) && (cnt_q < lim);
  assign done = (cnt_q == lim) && !rd_v_q && !prod_v_q && !cand_v_q;
  assign j_last = (CNTW'(j_q) + CNTW'(1)) == CNTW'(s_use);
  assign o_last = (NW'(o_q) + NW'(1)) == step_q;

  // metric read with reset value for entries not yet written this sequence
  logic signed [31:0] mval, new_metric, score_d;
  assign mval = mvld_rd_q ? m_rd_q : (mzero_rd_q ? 32'sd0 : FLOOR_METRIC);
  assign new_metric = ((best_q == FLOOR_METRIC) || (score_q == FLOOR_METRIC)) ?
                      FLOOR_METRIC : sat_add(best_q, score_q);
  // floor toward minus infinity by arithmetic shift; an exact zero sum is the floor
  assign score_d = (acc_q == '0) ? FLOOR_METRIC : 32'(acc_q >>> 15);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (frame_end) begin
          state_d = (int'(step_q) < MAX_STEPS) ? ST_EMIS : ST_FEND;
        end
      end
      ST_EMIS:      if (done) state_d = ST_ACS;
      ST_ACS:       if (done) state_d = ST_WRITE;
      ST_WRITE:     state_d = j_last ? ST_COPY : ST_EMIS;
      ST_COPY:      if (done) state_d = ST_FEND;
      ST_FEND:      state_d = eos_q ? ST_FIND : ST_IDLE;
      ST_FIND:      if (done) state_d = ST_WALK;
      ST_WALK:      state_d = (walk_q == '0) ? ST_OUT_RD : ST_WALK_WAIT;
      ST_WALK_WAIT: state_d = ST_WALK;
      ST_OUT_RD:    state_d = ST_OUT_LD;
      ST_OUT_LD:    state_d = ST_OUT_WAIT;
      ST_OUT_WAIT:  if (out_acc) state_d = o_last ? ST_RESTART : ST_OUT_RD;
      ST_RESTART:   state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_i.ready  = (state_q == ST_IDLE);
    out_o.valid = (state_q == ST_OUT_WAIT);
    out_o.data  = out_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      states_q   <= RESET_STATES;
      symbols_q  <= RESET_SYMBOLS;
      cnt_q      <= '0;
      j_q        <= '0;
      rd_v_q     <= 1'b0;
      prod_v_q   <= 1'b0;
      cand_v_q   <= 1'b0;
      rd_idx_q   <= '0;
      cand_idx_q <= '0;
      eos_q      <= 1'b0;
      step_q     <= '0;
      ovf_q      <= 1'b0;
      mvld_q     <= '0;
      wvld_q     <= '0;
      walk_q     <= '0;
      cur_q      <= '0;
      o_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        if (paddr[2] == REG_STATES) states_q <= pwdata[6:0];
        else                        symbols_q <= pwdata[4:0];
      end

      if (state_d != state_q) cnt_q <= '0;
      else if (issue)         cnt_q <= cnt_q + CNTW'(1);

      rd_v_q     <= issue;
      rd_idx_q   <= cnt_q[SW-1:0];
      prod_v_q   <= rd_v_q && (state_q == ST_EMIS);
      cand_v_q   <= rd_v_q && (state_q == ST_ACS);
      cand_idx_q <= rd_idx_q;

      if (state_q == ST_IDLE) j_q <= '0;
      else if (state_q == ST_WRITE) j_q <= j_q + SW'(1);

      if (in_acc && (in_i.data.action == ACT_OBS)) begin
        if (int'(in_i.data.column) < MAX_SYMBOLS) wvld_q[in_i.data.column[MW-1:0]] <= 1'b1;
        eos_q <= in_i.data.last_of_sequence;
      end

      if (rd_v_q && (state_q == ST_COPY)) mvld_q[rd_idx_q] <= 1'b1;

      if (state_q == ST_FEND) begin
        wvld_q <= '0;
        if (int'(step_q) < MAX_STEPS) step_q <= step_q + NW'(1);
        else                          ovf_q  <= 1'b1;
      end

      if ((state_q == ST_FIND) && (state_d == ST_WALK)) begin
        walk_q <= TW'(step_q - NW'(1));
        cur_q  <= pred_q;
      end
      if (state_q == ST_WALK_WAIT) begin
        cur_q  <= bp_rd_q;
        walk_q <= walk_q - TW'(1);
      end

      if (state_q == ST_IDLE) o_q <= '0;
      else if ((state_q == ST_OUT_WAIT) && out_acc) o_q <= o_q + TW'(1);

      if (state_q == ST_RESTART) begin
        mvld_q <= '0;
        wvld_q <= '0;
        step_q <= '0;
        ovf_q  <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (rd_v_q && (state_q == ST_EMIS)) begin
      prod_q <= (wvld_rd_q ? w_rd_q : 16'sd0) * e_rd_q;
    end
    if (state_q != ST_EMIS) acc_q <= '0;
    else if (prod_v_q)      acc_q <= acc_q + AW'(prod_q);
    if ((state_q == ST_EMIS) && (state_d == ST_ACS)) score_q <= score_d;

    if (rd_v_q && (state_q == ST_ACS)) begin
      cand_q <= (mval == FLOOR_METRIC) ? FLOOR_METRIC : sat_add(mval, 32'(t_rd_q));
    end

    // first maximum wins: strict compare
    if (((state_d == ST_ACS) && (state_q != ST_ACS)) ||
        ((state_d == ST_FIND) && (state_q != ST_FIND))) begin
      best_q <= FLOOR_METRIC;
      pred_q <= '0;
    end else if (cand_v_q && (cand_q > best_q)) begin
      best_q <= cand_q;
      pred_q <= cand_idx_q;
    end else if (rd_v_q && (state_q == ST_FIND) && (mval > best_q)) begin
      best_q <= mval;
      pred_q <= rd_idx_q;
    end

    if (state_q == ST_OUT_LD) begin
      out_q.state_index <= 6'(seq_rd_q);
      out_q.step_index  <= 6'(o_q);
      out_q.path_score  <= best_q;
      out_q.overflow    <= ovf_q;
      out_q.last        <= o_last;
    end
  end

  // ---------------- memories ----------------
  logic signed [15:0] trans_mem [MAX_STATES*MAX_STATES];
  logic signed [15:0] emis_mem  [MAX_STATES*MAX_SYMBOLS];
  logic signed [15:0] wgt_mem   [MAX_SYMBOLS];
  logic signed [31:0] metric_mem[MAX_STATES];
  logic signed [31:0] next_mem  [MAX_STATES];
  logic [SW-1:0]      bp_mem    [MAX_STEPS*MAX_STATES];
  logic [SW-1:0]      seq_mem   [MAX_STEPS];

  logic tbl_we, emis_we, obs_we;
  assign tbl_we  = in_acc && (in_i.data.action == ACT_TRANS) &&
                   (int'(in_i.data.row) < MAX_STATES) && (int'(in_i.data.column) < MAX_STATES);
  assign emis_we = in_acc && (in_i.data.action == ACT_EMIS) &&
                   (int'(in_i.data.row) < MAX_STATES) && (int'(in_i.data.column) < MAX_SYMBOLS);
  assign obs_we  = in_acc && (in_i.data.action == ACT_OBS) &&
                   (int'(in_i.data.column) < MAX_SYMBOLS);

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      trans_mem[TAW'(in_i.data.row) * TAW'(MAX_STATES) + TAW'(in_i.data.column)]
        <= in_i.data.value;
    end
    t_rd_q <= trans_mem[TAW'(cnt_q[SW-1:0]) * TAW'(MAX_STATES) + TAW'(j_q)];
  end

  always_ff @(posedge clk_i) begin
    if (emis_we) begin
      emis_mem[EAW'(in_i.data.row) * EAW'(MAX_SYMBOLS) + EAW'(in_i.data.column)]
        <= in_i.data.value;
    end
    e_rd_q <= emis_mem[EAW'(j_q) * EAW'(MAX_SYMBOLS) + EAW'(cnt_q[MW-1:0])];
  end

  always_ff @(posedge clk_i) begin
    if (obs_we) wgt_mem[in_i.data.column[MW-1:0]] <= in_i.data.value;
    w_rd_q    <= wgt_mem[cnt_q[MW-1:0]];
    wvld_rd_q <= wvld_q[cnt_q[MW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q && (state_q == ST_COPY)) metric_mem[rd_idx_q] <= n_rd_q;
    m_rd_q     <= metric_mem[cnt_q[SW-1:0]];
    mvld_rd_q  <= mvld_q[cnt_q[SW-1:0]];
    mzero_rd_q <= (cnt_q[SW-1:0] == '0);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) next_mem[j_q] <= new_metric;
    n_rd_q <= next_mem[cnt_q[SW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) begin
      bp_mem[BAW'(step_q) * BAW'(MAX_STATES) + BAW'(j_q)] <= pred_q;
    end
    bp_rd_q <= bp_mem[BAW'(walk_q) * BAW'(MAX_STATES) + BAW'(cur_q)];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WALK) seq_mem[walk_q] <= cur_q;
    seq_rd_q <= seq_mem[o_q];
  end

  // ---------------- assertions ----------------
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(step_q) <= MAX_STEPS)
    else $error("step count beyond capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (int'(step_q) == MAX_STEPS))
    else $error("overflow set with free step capacity");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input taken during result delivery");

  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_q.last) |=> (state_q == ST_RESTART))
    else $error("last result did not restart the sequence");

endmodule

// ----- verif/hmm_viterbi_decoder_test.sv -----
// hmm_viterbi_decoder_test: self-checking testbench for the HMM Viterbi decoder.
// Uses hvd_pkg and hvd_stream_if from the RTL; drives tables, frames and APB registers,
// predicts every decoded state and compares it field by field.
`timescale 1ns / 1ps

module hmm_viterbi_decoder_test;
  import hvd_pkg::*;

  localparam int NSTATE = 64;
  localparam int NSYM   = 16;
  localparam int NSTEP  = 64;

  // decodes run over the first TB_STATES states; their table words are loaded up front
  localparam int TB_STATES = 4;

  // action code the block ignores
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // Decoder model plus the store of decoded states still owed by the block.
  class viterbi_scoreboard;
    logic signed [15:0] trans_lp[NSTATE*NSTATE];
    logic signed [15:0] emis_lp[NSTATE*NSYM];
    logic signed [15:0] weight[NSYM];
    longint             metric[NSTATE];
    logic [5:0]         back_ptr[NSTEP*NSTATE];
    int unsigned        frames;
    bit                 ovf;
    logic [6:0]         states_reg;
    logic [4:0]         symbols_reg;
    hvd_out_t           decoded_q[$];
    int                 errors;

    function new();
      foreach (trans_lp[i]) trans_lp[i] = '0;
      foreach (emis_lp[i]) emis_lp[i] = '0;
      foreach (back_ptr[i]) back_ptr[i] = '0;
      states_reg  = RESET_STATES;
      symbols_reg = RESET_SYMBOLS;
      errors      = 0;
      restart();
    endfunction

    function void restart();
      foreach (metric[i]) metric[i] = longint'(FLOOR_METRIC);
      metric[0] = 0;
      frames    = 0;
      ovf       = 0;
      foreach (weight[i]) weight[i] = '0;
    endfunction

    function void set_reg(logic idx, logic [31:0] v);
      if (idx == REG_STATES) states_reg = v[6:0];
      else symbols_reg = v[4:0];
    endfunction

    function int n_states();
      if (states_reg == 0) return 1;
      if (states_reg > NSTATE) return NSTATE;
      return states_reg;
    endfunction

    function int n_symbols();
      if (symbols_reg == 0) return 1;
      if (symbols_reg > NSYM) return NSYM;
      return symbols_reg;
    endfunction

    function longint sat32(longint v);
      if (v > longint'(MAX_METRIC)) return longint'(MAX_METRIC);
      if (v < longint'(FLOOR_METRIC)) return longint'(FLOOR_METRIC);
      return v;
    endfunction

    // dot product Q1.15 x Q8.8 -> Q24.8, floor rounding; exact zero means impossible
    function longint emis_score(int j, int m);
      longint sum;
      sum = 0;
      for (int k = 0; k < m; k++)
        sum += longint'(weight[k]) * longint'(emis_lp[j*NSYM+k]);
      if (sum == 0) return longint'(FLOOR_METRIC);
      return sat32(sum >>> 15);
    endfunction

    function void acs_pass();
      longint nxt[NSTATE];
      longint best, cand, sc;
      int s, m, pred;
      s = n_states();
      m = n_symbols();
      for (int j = 0; j < s; j++) begin
        best = longint'(FLOOR_METRIC);
        pred = 0;
        for (int k = 0; k < s; k++) begin
          cand = metric[k];
          if (cand != longint'(FLOOR_METRIC))
            cand = sat32(cand + longint'(trans_lp[k*NSTATE+j]));
          if (cand > best) begin
            best = cand;
            pred = k;
          end
        end
        sc = emis_score(j, m);
        nxt[j] = (best == longint'(FLOOR_METRIC) || sc == longint'(FLOOR_METRIC)) ?
                 longint'(FLOOR_METRIC) : sat32(best + sc);
        back_ptr[frames*NSTATE+j] = pred[5:0];
      end
      for (int j = 0; j < s; j++) metric[j] = nxt[j];
    endfunction

    function void trace_path();
      int seq[NSTEP];
      longint best;
      int bs, n;
      hvd_out_t r;
      n = frames;
      if (n == 0) return;
      best = longint'(FLOOR_METRIC);
      bs = 0;
      for (int i = 0; i < n_states(); i++)
        if (metric[i] > best) begin
          best = metric[i];
          bs = i;
        end
      seq[n-1] = bs;
      for (int i = n - 1; i > 0; i--) seq[i-1] = back_ptr[i*NSTATE+seq[i]];
      for (int i = 0; i < n; i++) begin
        r.state_index = seq[i][5:0];
        r.step_index  = i[5:0];
        r.path_score  = best[31:0];
        r.overflow    = ovf;
        r.last        = (i == n - 1);
        decoded_q.push_back(r);
      end
    endfunction

    // called for every accepted input transaction
    function void note_input(hvd_in_t it);
      case (it.action)
        ACT_TRANS: trans_lp[{it.row, it.column}] = it.value;
        ACT_EMIS:  if (it.column < NSYM) emis_lp[it.row*NSYM+it.column] = it.value;
        ACT_OBS: begin
          if (it.column < NSYM) weight[it.column] = it.value;
          if (it.last_of_frame) begin
            if (frames < NSTEP) begin
              acs_pass();
              frames++;
            end else begin
              ovf = 1;
            end
            foreach (weight[i]) weight[i] = '0;
            if (it.last_of_sequence) begin
              trace_path();
              restart();
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void fail_note(string what, hvd_out_t e, hvd_out_t g);
      errors++;
      if (errors <= 10)
        $display({"MISMATCH %s: exp state %0d step %0d score %0d ovf %0b last %0b,",
                  " got state %0d step %0d score %0d ovf %0b last %0b"},
                 what, e.state_index, e.step_index, e.path_score, e.overflow, e.last,
                 g.state_index, g.step_index, g.path_score, g.overflow, g.last);
    endfunction

    // called for every accepted output transaction
    function void check(hvd_out_t got);
      hvd_out_t e;
      if (decoded_q.size() == 0) begin
        fail_note("unexpected", '0, got);
        return;
      end
      e = decoded_q.pop_front();
      if (got.state_index != e.state_index) fail_note("state_index", e, got);
      else if (got.step_index != e.step_index) fail_note("step_index", e, got);
      else if (got.path_score != e.path_score) fail_note("path_score", e, got);
      else if (got.overflow != e.overflow) fail_note("overflow", e, got);
      else if (got.last != e.last) fail_note("last", e, got);
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  hvd_stream_if #(.payload_t(hvd_in_t))  in_ch();
  hvd_stream_if #(.payload_t(hvd_out_t)) out_ch();

  hmm_viterbi_decoder uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch.sink),
    .out_o   (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  viterbi_scoreboard sb = new();

  // sender burst state, receiver hold-off request
  int burst_left = 0;
  bit gaps_on    = 1;
  int hold_req   = 0;
  int hold_left  = 0;
  int rx_mode    = 0;
  int rx_mode_left = 0;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
  end

  // monitors: sample pre-edge values, driver updates are nonblocking
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check(out_ch.data);
  end

  // receiver: picks a new random mode when its mode counter runs out; a hold-off request
  // stalls it flat for a counted stretch
  always @(posedge clk_i) begin
    logic rdy;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(10, 60);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0, 1: rdy = 1'b1;
      2:    rdy = $urandom_range(0, 1);
      default: rdy = ($urandom_range(0, 4) == 0);
    endcase
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end
    out_ch.ready <= rdy;
  end

  function automatic hvd_in_t mk(logic [1:0] a, logic [5:0] r, logic [5:0] c,
                                 logic [15:0] v, logic eof, logic eos);
    hvd_in_t it;
    it.action = a;
    it.row = r;
    it.column = c;
    it.value = v;
    it.last_of_frame = eof;
    it.last_of_sequence = eos;
    return it;
  endfunction

  // called right after a rising edge; leaves valid high for the next transaction
  task automatic send(hvd_in_t it);
    if (gaps_on && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // APB write: setup then access; register taken at the access edge
  task automatic reg_write(logic idx, logic [31:0] v);
    drain();
    repeat (40) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // one observation frame of m weights; mostly in-range columns with some noise
  task automatic send_frame(int m, logic eos);
    for (int k = 0; k < m; k++) begin
      logic [5:0] col;
      col = ($urandom_range(0, 9) == 0) ? 6'($urandom()) : 6'(k);
      send(mk(ACT_OBS, 6'($urandom()), col, rand_val(), k == m - 1,
              (k == m - 1) ? eos : 1'($urandom())));
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send(mk(ACT_TRANS, 6'($urandom()), 6'($urandom()), rand_val(), 1'($urandom()),
                 1'($urandom())));
      1: send(mk(ACT_EMIS, 6'($urandom()), 6'($urandom()), rand_val(), 1'($urandom()),
                 1'($urandom())));
      2: send(mk(ACT_SPARE, 6'($urandom()), 6'($urandom()), 16'($urandom()),
                 1'($urandom()), 1'($urandom())));
      default: send(mk(ACT_OBS, 6'($urandom()), 6'($urandom_range(16, 63)),
                       16'($urandom()), 1'b0, 1'($urandom())));
    endcase
  endtask

  task automatic run_sequence(int nframes, int m);
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int f = 0; f < nframes; f++) begin
      if ($urandom_range(0, 3) == 0) send_noise();
      send_frame(m, f == nframes - 1);
    end
  endtask

  initial begin
    int s_set[6] = '{1, 0, 4, 3, 4, 2};
    int m_set[6] = '{1, 0, 3, 5, 31, 16};
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: edge-case transactions under the reset register values
    send(mk(ACT_SPARE, 6'h3f, 6'h3f, 16'hffff, 1'b1, 1'b1));
    send(mk(ACT_OBS, 6'h3f, 6'd40, 16'h7fff, 1'b0, 1'b1));
    send(mk(ACT_EMIS, 6'h3f, 6'd20, 16'h1234, 1'b1, 1'b1));
    send(mk(ACT_TRANS, 6'h3f, 6'h3f, 16'h8000, 1'b1, 1'b1));

    // decode over the loaded corner of the tables only
    reg_write(REG_STATES, TB_STATES);
    reg_write(REG_SYMBOLS, NSYM);

    // load every table word that a decode can read
    gaps_on = 0;
    for (int i = 0; i < TB_STATES*TB_STATES; i++)
      send(mk(ACT_TRANS, 6'(i / TB_STATES), 6'(i % TB_STATES), rand_val(), 1'b0, 1'b0));
    for (int i = 0; i < TB_STATES*NSYM; i++)
      send(mk(ACT_EMIS, 6'(i / NSYM), 6'(i % NSYM), rand_val(), 1'b0, 1'b0));
    gaps_on = 1;

    // weight extremes
    send(mk(ACT_OBS, 6'd0, 6'd0, 16'h7fff, 1'b0, 1'b0));
    send(mk(ACT_OBS, 6'd0, 6'd15, 16'h8000, 1'b1, 1'b0));
    // all-zero weights: every score is impossible, then whole path is at the floor
    send(mk(ACT_OBS, 6'd0, 6'd1, 16'h0000, 1'b1, 1'b1));
    drain();

    // ties: two identical states, equal transitions
    reg_write(REG_STATES, 32'd2);
    reg_write(REG_SYMBOLS, 32'd1);
    for (int i = 0; i < 4; i++)
      send(mk(ACT_TRANS, 6'(i / 2), 6'(i % 2), 16'h0000, 1'b0, 1'b0));
    send(mk(ACT_EMIS, 6'd0, 6'd0, 16'h0100, 1'b0, 1'b0));
    send(mk(ACT_EMIS, 6'd1, 6'd0, 16'h0100, 1'b0, 1'b0));
    send(mk(ACT_OBS, 6'd0, 6'd0, 16'h4000, 1'b1, 1'b0));
    send(mk(ACT_OBS, 6'd0, 6'd0, 16'h4000, 1'b1, 1'b1));

    // too many frames: 65 frames in one sequence sets overflow
    for (int f = 0; f < 65; f++)
      send(mk(ACT_OBS, 6'($urandom()), 6'd0, rand_val(), 1'b1, f == 64));
    drain();

    // random phases over several register settings, extremes included
    for (int p = 0; p < 6; p++) begin
      int m, nseq;
      reg_write(REG_STATES, s_set[p]);
      reg_write(REG_SYMBOLS, m_set[p]);
      m = sb.n_symbols();
      nseq = (m > 8) ? 1 : 2;
      for (int q = 0; q < nseq; q++) begin
        if (p == 2 && q == 0) hold_req = 600;  // block fills up while sender keeps going
        run_sequence((m > 8) ? 1 : $urandom_range(1, 4), m);
      end
      // states shrink mid-sequence; earlier back pointers still cover the path
      if (p == 3) begin
        send_frame(m, 1'b0);
        in_ch.valid <= 1'b0;
        repeat (1000) @(posedge clk_i);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {REG_STATES, 2'b00}; pwdata <= 32'd2;
        @(posedge clk_i);
        penable <= 1'b1;
        @(posedge clk_i);
        sb.set_reg(REG_STATES, 32'd2);
        psel <= 1'b0; penable <= 1'b0;
        send_frame(m, 1'b0);
        send_frame(m, 1'b1);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #30ms;
    $display("Verification failed");
    $finish;
  end

endmodule
